[hdl/mspt_pkg.sv]
package mspt_pkg;

  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 2;
  localparam int MASK_W   = 4;
  localparam int COUNT_W  = 32;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd2;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // request broadcast to every cell
  typedef struct packed {
    logic add;   // add request with nonzero count
    logic tick;  // tick request
  } cell_cmd_t;

  // per-cell report
  typedef struct packed {
    logic busy;
    logic taken;
    logic expired;
    logic freed;
  } cell_stat_t;

endpackage

[hdl/multi_slot_periodic_timer_core.sv]
// A request accepted at a clock edge has its result registered on the out_ ports
//   at that edge; it stays until taken.
// Throughput: one request per cycle; in_ready stays high while the result
//   register is empty or being drained. The lowest-free-slot search ripples
//   through the row of slot cells within that cycle.
// Reset (rst_n low, synchronous): all slots freed, both counts zeroed, no result pending.
module multi_slot_periodic_timer_core
  import mspt_pkg::*;
#(
  parameter int SLOTS = 4
)
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [COUNT_W-1:0]  in_count,
  input  logic [MASK_W-1:0]   in_stop_mask,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [MASK_W-1:0]   out_expired_mask,
  output logic [MASK_W-1:0]   out_freed_mask
);

  // Slots at index 4 and up have no stop bit and no place in the 4-bit masks.
  localparam int VIS = (SLOTS < MASK_W) ? SLOTS : MASK_W;

  logic                fire;
  logic                count_zero;
  cell_cmd_t           cmd;
  logic [SLOTS:0]      claim;      // ripple: some lower slot is free
  cell_stat_t          stat [SLOTS];
  logic [SLOTS-1:0]    busy;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [MASK_W-1:0]   expired_r, expired_nxt;
  logic [MASK_W-1:0]   freed_r, freed_nxt;

  // Output register decouples the sides: a new request enters while the
  // current result is being taken.
  assign in_ready   = !out_valid_r || out_ready;
  assign fire       = in_valid && in_ready;
  assign count_zero = (in_count == '0);

  // A zero-count add never reaches the cells, so state stays untouched.
  assign cmd.add  = fire && (in_command == CMD_ADD) && !count_zero;
  assign cmd.tick = fire && (in_command == CMD_TICK);

  assign claim[0] = 1'b0;

  // Row of slot cells; the free-slot claim is handed from cell to cell.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic stop_bit;
    if (i < MASK_W) begin : g_stop
      assign stop_bit = in_stop_mask[i];
    end else begin : g_nostop
      assign stop_bit = 1'b0;
    end

    mspt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .count     (in_count),
      .stop      (stop_bit),
      .claim_in  (claim[i]),
      .claim_out (claim[i+1]),
      .stat      (stat[i])
    );

    assign busy[i] = stat[i].busy;
  end

  // Result assembly.
  always_comb begin
    status_nxt  = ST_OK;
    slot_nxt    = '0;
    expired_nxt = '0;
    freed_nxt   = '0;
    if (in_command == CMD_ADD) begin
      if (count_zero) begin
        status_nxt = ST_ZERO_COUNT;
      end else if (!claim[SLOTS]) begin
        status_nxt = ST_NO_SLOT;
      end else begin
        // taken is one-hot; slot number is reported modulo 4
        for (int i = 0; i < SLOTS; i++) begin
          if (stat[i].taken) begin
            slot_nxt = slot_nxt | SLOT_W'(i);
          end
        end
      end
    end else begin
      for (int i = 0; i < VIS; i++) begin
        expired_nxt[i] = stat[i].expired;
        freed_nxt[i]   = stat[i].freed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status_nxt;
      slot_r    <= slot_nxt;
      expired_r <= expired_nxt;
      freed_r   <= freed_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_slot         = slot_r;
  assign out_expired_mask = expired_r;
  assign out_freed_mask   = freed_r;

  // A freed slot must also be reported as expired.
  a_freed_in_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((freed_r & ~expired_r) == '0))
    else $error("freed slot not marked expired");

  // Rejected add carries no slot and no masks.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |->
      (slot_r == '0 && expired_r == '0 && freed_r == '0))
    else $error("rejected add has nonzero fields");

  // No-slot rejection only when every slot is busy (state unchanged by it).
  a_no_slot_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_command == CMD_ADD && !count_zero && !claim[SLOTS]) |=>
      (&busy && status_r == ST_NO_SLOT))
    else $error("no-slot reject with a free slot");

  // An accepted add with a free slot makes that slot busy.
  a_add_claims: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add && claim[SLOTS] |=> (out_valid_r && status_r == ST_OK &&
      $countones(busy) == $countones($past(busy)) + 1))
    else $error("add did not claim exactly one slot");

endmodule

[hdl/mspt_cell.sv]
module mspt_cell
  import mspt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_cmd_t          cmd,
  input  logic [COUNT_W-1:0] count,
  input  logic               stop,
  input  logic               claim_in,   // a lower slot already free
  output logic               claim_out,
  output cell_stat_t         stat
);

  logic [COUNT_W-1:0] reload_r, reload_nxt;
  logic [COUNT_W-1:0] current_r, current_nxt;
  logic [COUNT_W-1:0] dec;
  logic               free;
  logic               hit;
  logic               take;

  assign free      = (reload_r == '0);
  assign dec       = current_r - COUNT_W'(1);
  assign hit       = !free && (dec == '0);
  assign take      = cmd.add && free && !claim_in;
  assign claim_out = claim_in || free;

  always_comb begin
    reload_nxt  = reload_r;
    current_nxt = current_r;
    if (take) begin
      reload_nxt  = count;
      current_nxt = count;
    end else if (cmd.tick && !free) begin
      if (hit) begin
        if (stop) begin
          reload_nxt  = '0;
          current_nxt = '0;
        end else begin
          current_nxt = reload_r;
        end
      end else begin
        current_nxt = dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r  <= '0;
      current_r <= '0;
    end else begin
      reload_r  <= reload_nxt;
      current_r <= current_nxt;
    end
  end

  assign stat.busy    = !free;
  assign stat.taken   = take;
  assign stat.expired = cmd.tick && hit;
  assign stat.freed   = cmd.tick && hit && stop;

endmodule
